// File: src/utf8d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants for the extended UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  // field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CodeW   = 36;
  localparam int unsigned CountW  = 3;
  localparam int unsigned ContW   = 6;

  // default longest sequence a lead may declare
  localparam int unsigned MaxSeqLenDefault = 7;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_TRUNC   = 2'd2
  } status_e;

  // one input item
  typedef struct packed {
    logic [ByteW-1:0] in_byte;
    logic             end_of_string;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic [CodeW-1:0]  code_point;
    logic [CountW-1:0] seq_bytes;
    status_e           status;
    logic              last;
  } out_item_t;

endpackage

// File: src/utf8_stream_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// Extended UTF-8 byte-stream decoder, sequences of 1 to MAX_SEQ_LEN bytes.
// ----------------------------------------------------------------------------
// The decoder takes one byte per clock cycle, back to back, and gives one
// result for each complete sequence, invalid lead byte, or string that ends
// mid-sequence. Each result is registered before it shows on the output. The
// sequence state (bytes left, accumulator, count) updates in the same cycle a
// byte is taken, so the state loop sets the rate of one byte per cycle unless
// stalled. A two-entry output buffer (result register plus skid register)
// lets input bytes keep flowing while a result waits to be taken; input
// stalls only when both entries are full. Continuation bytes are not
// checked, and a truncated sequence reports the payload gathered so far.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top #(
  parameter int unsigned MAX_SEQ_LEN = utf8d_pkg::MaxSeqLenDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  utf8d_pkg::in_item_t  in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output utf8d_pkg::out_item_t out_o
);

  localparam int unsigned CodeW  = utf8d_pkg::CodeW;
  localparam int unsigned CountW = utf8d_pkg::CountW;
  localparam int unsigned ByteW  = utf8d_pkg::ByteW;
  localparam int unsigned ContW  = utf8d_pkg::ContW;

  // sequence state
  logic [CountW-1:0] bytes_left_q, bytes_left_d;
  logic [CodeW-1:0]  acc_q, acc_d;
  logic [CountW-1:0] seq_total_q, seq_total_d;

  // output buffer
  logic                 out_valid_q;
  utf8d_pkg::out_item_t out_q;
  logic                 skid_valid_q;
  utf8d_pkg::out_item_t skid_q;

  logic                 in_fire;
  logic                 pop;
  logic                 push;
  logic                 has_res;
  utf8d_pkg::out_item_t res;

  logic [ByteW-1:0] b;
  logic             eos;
  logic [3:0]       lead_len;
  logic [CodeW-1:0] lead_payload;
  logic [CodeW-1:0] acc_cont;

  assign in_ready_o  = !skid_valid_q;
  assign in_fire     = in_valid_i && in_ready_o;
  assign pop         = out_valid_q && out_ready_i;
  assign push        = in_fire && has_res;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  assign b   = in_i.in_byte;
  assign eos = in_i.end_of_string;

  // count of leading one bits of the byte
  always_comb begin
    logic stop;
    stop     = 1'b0;
    lead_len = '0;
    for (int i = ByteW - 1; i >= 0; i--) begin
      if (!stop) begin
        if (b[i]) begin
          lead_len = lead_len + 4'd1;
        end else begin
          stop = 1'b1;
        end
      end
    end
  end

  // lead payload keeps the low (7 - length) bits
  assign lead_payload = CodeW'(b & (8'h7F >> lead_len));
  // continuation adds six low bits
  assign acc_cont     = {acc_q[CodeW-ContW-1:0], b[ContW-1:0]};

  // next state and result for the byte on the input
  always_comb begin
    bytes_left_d = bytes_left_q;
    acc_d        = acc_q;
    seq_total_d  = seq_total_q;
    has_res      = 1'b0;
    res          = '0;
    if (bytes_left_q == '0) begin
      if (!b[ByteW-1]) begin
        has_res        = 1'b1;
        res.code_point = CodeW'(b);
        res.seq_bytes  = CountW'(1);
        res.status     = utf8d_pkg::ST_OK;
        res.last       = eos;
      end else if (lead_len < 4'd2 || lead_len > 4'(MAX_SEQ_LEN)) begin
        has_res        = 1'b1;
        res.code_point = '0;
        res.seq_bytes  = CountW'(1);
        res.status     = utf8d_pkg::ST_INVALID;
        res.last       = eos;
      end else if (eos) begin
        has_res        = 1'b1;
        res.code_point = lead_payload;
        res.seq_bytes  = CountW'(1);
        res.status     = utf8d_pkg::ST_TRUNC;
        res.last       = 1'b1;
      end else begin
        acc_d        = lead_payload;
        seq_total_d  = CountW'(1);
        bytes_left_d = CountW'(lead_len - 4'd1);
      end
    end else begin
      res.code_point = acc_cont;
      res.seq_bytes  = seq_total_q + CountW'(1);
      if (bytes_left_q == CountW'(1)) begin
        has_res    = 1'b1;
        res.status = utf8d_pkg::ST_OK;
        res.last   = eos;
      end else if (eos) begin
        has_res    = 1'b1;
        res.status = utf8d_pkg::ST_TRUNC;
        res.last   = 1'b1;
      end
      if (has_res) begin
        acc_d        = '0;
        seq_total_d  = '0;
        bytes_left_d = '0;
      end else begin
        acc_d        = acc_cont;
        seq_total_d  = seq_total_q + CountW'(1);
        bytes_left_d = bytes_left_q - CountW'(1);
      end
    end
  end

  // sequence state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= '0;
      acc_q        <= '0;
      seq_total_q  <= '0;
    end else if (in_fire) begin
      bytes_left_q <= bytes_left_d;
      acc_q        <= acc_d;
      seq_total_q  <= seq_total_d;
    end
  end

  // output control: result register with skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  // skid entry is only used behind a held result
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid without result register valid");

  // an invalid lead answers code 0 over one byte
  a_invalid_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == utf8d_pkg::ST_INVALID) |->
      (out_q.code_point == '0 && out_q.seq_bytes == CountW'(1)))
    else $error("invalid lead result malformed");

  // truncation always closes the string
  a_trunc_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == utf8d_pkg::ST_TRUNC) |-> out_q.last)
    else $error("truncated result without last");

  // an open sequence has taken at least its lead
  a_open_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bytes_left_q != '0) |-> (seq_total_q != '0))
    else $error("open sequence with zero bytes taken");

  // a held result stays while the sink stalls
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("result changed while stalled");

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the extended UTF-8 stream decoder. Bytes from a
// queue go in with random gaps and results are taken with random stalls.
// A behavioral decoder predicts each result, and the bench checks it field
// by field in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MaxSeqLen  = 7;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned RandBytes  = 1700;
  localparam int unsigned MaxReports = 10;

  localparam int unsigned ByteW  = utf8d_pkg::ByteW;
  localparam int unsigned CodeW  = utf8d_pkg::CodeW;
  localparam int unsigned CountW = utf8d_pkg::CountW;
  localparam int unsigned ContW  = utf8d_pkg::ContW;

  // one byte waiting to be sent; hold marks a pause until all results are in
  typedef struct {
    utf8d_pkg::in_item_t item;
    bit                  hold;
  } tx_byte_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 out_ready_i = 1'b0;
  utf8d_pkg::in_item_t  in_i        = '0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  utf8d_pkg::out_item_t out_o;

  tx_byte_t             byte_q[$];
  utf8d_pkg::out_item_t code_q[$];

  // decoder state kept by the bench
  logic [CountW-1:0] cont_left;
  logic [CodeW-1:0]  code_acc;
  logic [CountW-1:0] seq_taken;

  int unsigned byte_cnt    = 0;
  int unsigned fail_cnt    = 0;
  int unsigned ok_cnt      = 0;
  int unsigned invalid_cnt = 0;
  int unsigned trunc_cnt   = 0;
  int unsigned idle_cycles = 0;

  utf8_stream_decoder_top #(
    .MAX_SEQ_LEN(MaxSeqLen)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  always #10 clk_i = ~clk_i;

  // stretches of back-to-back traffic on both sides
  function automatic bit no_idle_window();
    return (byte_cnt % 400) >= 300;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned count_lead_ones(logic [ByteW-1:0] b);
    int unsigned n;
    n = 0;
    while (n < ByteW && b[ByteW-1-n]) n++;
    return n;
  endfunction

  function automatic void add_code(logic [CodeW-1:0] cp, logic [CountW-1:0] cnt,
                                   utf8d_pkg::status_e st, logic lst);
    utf8d_pkg::out_item_t r;
    r.code_point = cp;
    r.seq_bytes  = cnt;
    r.status     = st;
    r.last       = lst;
    code_q.push_back(r);
  endfunction

  function automatic void seq_idle();
    cont_left = '0;
    code_acc  = '0;
    seq_taken = '0;
  endfunction

  // predict the result, if any, of one accepted byte
  function automatic void decode_byte(utf8d_pkg::in_item_t it);
    logic [ByteW-1:0] b;
    logic             eos;
    int unsigned      n;
    b   = it.in_byte;
    eos = it.end_of_string;
    if (cont_left == 0) begin
      if (!b[7]) begin
        add_code(CodeW'(b), 3'd1, utf8d_pkg::ST_OK, eos);
        return;
      end
      n = count_lead_ones(b);
      if (n < 2 || n > MaxSeqLen) begin
        add_code('0, 3'd1, utf8d_pkg::ST_INVALID, eos);
        return;
      end
      code_acc      = '0;
      code_acc[7:0] = b & 8'((1 << (7 - n)) - 1);
      seq_taken     = 3'd1;
      cont_left     = CountW'(n - 1);
      if (eos) begin
        add_code(code_acc, seq_taken, utf8d_pkg::ST_TRUNC, 1'b1);
        seq_idle();
      end
      return;
    end
    // any byte inside an open sequence counts as a continuation
    code_acc  = {code_acc[CodeW-7:0], b[ContW-1:0]};
    seq_taken = seq_taken + 3'd1;
    cont_left = cont_left - 3'd1;
    if (cont_left == 0) begin
      add_code(code_acc, seq_taken, utf8d_pkg::ST_OK, eos);
      seq_idle();
    end else if (eos) begin
      add_code(code_acc, seq_taken, utf8d_pkg::ST_TRUNC, 1'b1);
      seq_idle();
    end
  endfunction

  function automatic void push_byte(logic [ByteW-1:0] b, logic eos, bit hold);
    tx_byte_t t;
    t.item.in_byte       = b;
    t.item.end_of_string = eos;
    t.hold               = hold;
    byte_q.push_back(t);
  endfunction

  // a sequence declaring len bytes, of which only the first stop are sent
  function automatic void push_seq(int unsigned len, int unsigned stop, logic eos);
    logic [ByteW-1:0] b;
    for (int unsigned i = 0; i < stop; i++) begin
      if (i == 0 && len == 1) begin
        b = 8'($urandom_range(0, 127));
      end else if (i == 0) begin
        b = (8'hFF << (8 - len)) | 8'($urandom & ((1 << (7 - len)) - 1));
      end else if ($urandom_range(0, 7) == 0) begin
        b = 8'($urandom_range(0, 255));
      end else begin
        b = 8'h80 | 8'($urandom_range(0, 63));
      end
      push_byte(b, eos && (i == stop - 1), $urandom_range(0, 299) == 0);
    end
  endfunction

  // byte driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    bit          sent;
    int unsigned gap_left;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_i       <= '0;
      gap_left   = 0;
      seq_idle();
    end else begin
      sent = in_valid_i && in_ready_o;
      if (sent) begin
        decode_byte(in_i);
        byte_cnt++;
      end
      if (in_valid_i && !sent) begin
        // hold the item until taken
      end else if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (byte_q.size() != 0 && !(byte_q[0].hold && code_q.size() != 0)) begin
        in_i       <= byte_q[0].item;
        in_valid_i <= 1'b1;
        byte_q.pop_front();
        gap_left = pick_gap(no_idle_window());
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result monitor and checker
  always @(posedge clk_i or negedge rst_ni) begin : check_proc
    bit                   took;
    int unsigned          stall_left;
    utf8d_pkg::out_item_t exp_code;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left = 0;
    end else begin
      took = out_valid_o && out_ready_i;
      if (took) begin
        case (out_o.status)
          utf8d_pkg::ST_OK:      ok_cnt++;
          utf8d_pkg::ST_INVALID: invalid_cnt++;
          default:               trunc_cnt++;
        endcase
        if (code_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= MaxReports)
            $display("%0t: unexpected result cp=%h n=%0d st=%0d last=%0b", $realtime,
                     out_o.code_point, out_o.seq_bytes, out_o.status, out_o.last);
        end else begin
          exp_code = code_q.pop_front();
          if (out_o.code_point !== exp_code.code_point ||
              out_o.seq_bytes !== exp_code.seq_bytes ||
              out_o.status !== exp_code.status || out_o.last !== exp_code.last) begin
            fail_cnt++;
            if (fail_cnt <= MaxReports)
              $display("%0t: mismatch exp cp=%h n=%0d st=%0d last=%0b, ",
                       $realtime, exp_code.code_point, exp_code.seq_bytes,
                       exp_code.status, exp_code.last,
                       "got cp=%h n=%0d st=%0d last=%0b",
                       out_o.code_point, out_o.seq_bytes, out_o.status, out_o.last);
          end
        end
      end
      if (stall_left != 0) stall_left--;
      else if (took || $urandom_range(0, 7) == 0) stall_left = pick_gap(no_idle_window());
      out_ready_i <= (stall_left == 0);
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no handshake for %0d cycles", $realtime, idle_cycles);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // stimulus and end of run
  initial begin : stim_proc
    int unsigned r;
    int unsigned len;
    int unsigned stop;
    logic        eos;

    // single bytes, stray continuations and 0xFF
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'h7F, 1'b1, 1'b0);
    push_byte(8'h80, 1'b0, 1'b0);
    push_byte(8'hBF, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0);
    // seven-byte sequence with all payload bits set
    push_byte(8'hFE, 1'b0, 1'b0);
    for (int i = 0; i < 6; i++) push_byte(8'hBF, i == 5, 1'b0);
    // string ending right after a lead, then mid-sequence
    push_byte(8'hC2, 1'b1, 1'b0);
    push_byte(8'hE0, 1'b0, 1'b0);
    push_byte(8'h80, 1'b1, 1'b0);
    // leads and ascii taken as continuations inside a sequence
    push_byte(8'hF0, 1'b0, 1'b0);
    push_byte(8'hC1, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h00, 1'b0, 1'b0);
    // two-byte sequence, sent only after all results are in
    push_byte(8'hDF, 1'b0, 1'b1);
    push_byte(8'h3F, 1'b1, 1'b0);

    // random traffic: mostly well-formed sequences, some noise and cut strings
    while (byte_q.size() < RandBytes + 20) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        len  = $urandom_range(1, MaxSeqLen);
        stop = len;
        eos  = ($urandom_range(0, 5) == 0);
        if (len > 1 && $urandom_range(0, 9) == 0) begin
          stop = $urandom_range(1, len - 1);
          eos  = 1'b1;
        end
        push_seq(len, stop, eos);
      end else begin
        push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                  $urandom_range(0, 299) == 0);
      end
    end

    // release reset
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (byte_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (code_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (code_q.size() != 0) begin
      $display("%0d expected results never arrived", code_q.size());
      fail_cnt += code_q.size();
    end
    $display("sent %0d bytes; results: %0d ok, %0d invalid lead, %0d truncated",
             byte_cnt, ok_cnt, invalid_cnt, trunc_cnt);
    $display("%0d mismatches", fail_cnt);
    if (fail_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
